// ===== src/blm_pkg.sv =====
// blm_pkg: shared types and constants of the battery level monitor
// no dependencies; imported by every module under src

package blm_pkg;

	localparam int SAMPLE_W = 10;
	localparam int LEVEL_W  = 7;
	localparam int THR_W    = 7;
	localparam int INTV_W   = 8;
	localparam int COUNT_W  = 8;
	localparam int LAST_W   = 8;
	localparam int CFG_W    = 8;
	localparam int IDX_W    = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	// sum*720/(1024*N) reduces to sum*45/(64*N)
	localparam int SCALE_NUM   = 45;
	localparam int SCALE_SHIFT = 6;
	localparam int LEVEL_OFFSET = 310;
	localparam int LEVEL_SAT    = 255;
	localparam int LEVEL_MAX    = 100;

	localparam logic [THR_W-1:0]  THRESHOLD_RST = 7'd45;
	localparam logic [INTV_W-1:0] INTERVAL_RST  = 8'd6;
	localparam logic [LAST_W-1:0] LAST_RST      = 8'd255;

	typedef enum logic [IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_INTERVAL  = 2'd1,
		REG_NOTIFY_EN = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]  threshold;
		logic [INTV_W-1:0] interval;
		logic              notify_en;
	} cfg_t;

endpackage

// ===== src/battery_level_monitor.sv =====
// battery_level_monitor: top level, config registers and the three pipeline parts
// depends on blm_pkg, blm_window, blm_scale, blm_level
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata[9:0] adc_sample
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata[6:0] level, [7] notify, [8] shutdown
//  cfg      | in  | cfg_we (no wait)             | cfg_index, cfg_data
//
// one sample per cycle unless stalled; results pass sum, product, quotient and output registers
// pipeline: window+sum, multiply by 45, reciprocal divide by the window length, level logic
// each stage stalls only when the stage after it is full, so bubbles are squeezed out
// reset clears the window, slot, count, last level and config to their start values

module battery_level_monitor import blm_pkg::*; #(
	parameter int WINDOW_LEN = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] adc_sample
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [6:0] level_percent, [7] notify, [8] shutdown
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int SUM_W = SAMPLE_W + ((WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 0);

	cfg_t               cfg_q;
	logic               vld_s1;
	logic               rdy_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic               vld_s3;
	logic               rdy_s3;
	logic [SUM_W-1:0]   quot_s3;
	logic [LEVEL_W-1:0] level_q;
	logic               notify_q;
	logic               shutdown_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RST;
			cfg_q.interval  <= INTERVAL_RST;
			cfg_q.notify_en <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_THRESHOLD: cfg_q.threshold <= cfg_data[THR_W-1:0];
				REG_INTERVAL:  cfg_q.interval  <= cfg_data[INTV_W-1:0];
				REG_NOTIFY_EN: cfg_q.notify_en <= cfg_data[0];
				default: ;
			endcase
		end
	end

	blm_window #(
		.WINDOW_LEN(WINDOW_LEN),
		.SUM_W(SUM_W)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sample(s_axis_tdata[SAMPLE_W-1:0]),
		.vld_s1(vld_s1),
		.rdy_s1(rdy_s1),
		.sum_s1(sum_s1)
	);

	blm_scale #(
		.WINDOW_LEN(WINDOW_LEN),
		.SUM_W(SUM_W)
	) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.vld_s1(vld_s1),
		.rdy_s1(rdy_s1),
		.sum_s1(sum_s1),
		.vld_s3(vld_s3),
		.rdy_s3(rdy_s3),
		.quot_s3(quot_s3)
	);

	blm_level #(
		.SUM_W(SUM_W)
	) u_level (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.vld_s3(vld_s3),
		.rdy_s3(rdy_s3),
		.quot_s3(quot_s3),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.level_q(level_q),
		.notify_q(notify_q),
		.shutdown_q(shutdown_q)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - LEVEL_W - 2)'(0), shutdown_q, notify_q, level_q};

endmodule

// ===== src/blm_window.sv =====
// blm_window: sample window, write slot and window sum register (stage 1)
// depends on blm_pkg

module blm_window import blm_pkg::*; #(
	parameter int WINDOW_LEN = 5,
	parameter int SUM_W = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                vld_s1,
	input  logic                rdy_s1,
	output logic [SUM_W-1:0]    sum_s1
);

	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);

	logic [SAMPLE_W-1:0] window_q [WINDOW_LEN];
	logic [SAMPLE_W-1:0] window_nxt [WINDOW_LEN];
	logic [SLOT_W-1:0]   slot_q;
	logic                fill;
	logic                wrap;
	logic                fire;
	logic [SUM_W-1:0]    sum_nxt;

	assign in_ready = !vld_s1 || rdy_s1;
	assign fire     = in_valid && in_ready;
	// an empty first entry means the window has not been primed yet
	assign fill     = (window_q[0] == '0);
	assign wrap     = (slot_q == SLOT_LAST);

	always_comb begin
		logic [SUM_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			if (fill || slot_q == SLOT_W'(i)) begin
				window_nxt[i] = sample;
			end else begin
				window_nxt[i] = window_q[i];
			end
			acc = acc + SUM_W'(window_nxt[i]);
		end
		sum_nxt = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				window_q[i] <= '0;
			end
			slot_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (fire) begin
				for (int i = 0; i < WINDOW_LEN; i++) begin
					window_q[i] <= window_nxt[i];
				end
				if (!fill) begin
					slot_q <= wrap ? '0 : slot_q + 1'b1;
				end
				vld_s1 <= !fill && wrap;
			end else if (rdy_s1) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sum_s1 <= sum_nxt;
		end
	end

endmodule

// ===== src/blm_scale.sv =====
// blm_scale: scales the window sum to a percent-domain quotient (stages 2 and 3)
// depends on blm_pkg; division by the window length is a reciprocal multiply

module blm_scale import blm_pkg::*; #(
	parameter int WINDOW_LEN = 5,
	parameter int SUM_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_s1,
	output logic             rdy_s1,
	input  logic [SUM_W-1:0] sum_s1,
	output logic             vld_s3,
	input  logic             rdy_s3,
	output logic [SUM_W-1:0] quot_s3
);

	localparam int PROD_W = SUM_W + SCALE_SHIFT;
	localparam int LOG_N  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 0;
	localparam int RSHIFT = SUM_W + LOG_N + 1;
	localparam int RECIP_W = RSHIFT + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << RSHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

	logic [PROD_W-1:0]         prod_s2;
	logic                      vld_s2;
	logic                      rdy_s2;
	logic [SUM_W-1:0]          div_in;
	logic [SUM_W+RECIP_W-1:0]  recip_prod;

	assign rdy_s1 = !vld_s2 || rdy_s2;
	assign rdy_s2 = !vld_s3 || rdy_s3;

	// floor(x/64) then floor(/N) equals floor(x/(64*N))
	assign div_in     = prod_s2[SCALE_SHIFT +: SUM_W];
	assign recip_prod = (SUM_W+RECIP_W)'(div_in) * (SUM_W+RECIP_W)'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s2) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && vld_s1) begin
			prod_s2 <= PROD_W'(sum_s1) * PROD_W'(SCALE_NUM);
		end
		if (rdy_s2 && vld_s2) begin
			quot_s3 <= recip_prod[RSHIFT +: SUM_W];
		end
	end

endmodule

// ===== src/blm_level.sv =====
// blm_level: offset, saturation, running minimum, notify and shutdown flags
// depends on blm_pkg; holds the output register of the result stream

module blm_level import blm_pkg::*; #(
	parameter int SUM_W = 13
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   vld_s3,
	output logic                   rdy_s3,
	input  logic [SUM_W-1:0]       quot_s3,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [LEVEL_W-1:0]     level_q,
	output logic                   notify_q,
	output logic                   shutdown_q
);

	logic [LAST_W-1:0]  last_q;
	logic [COUNT_W-1:0] count_q;
	logic [LAST_W-1:0]  raw;
	logic [LAST_W-1:0]  lvl;
	logic [LEVEL_W-1:0] level;
	logic [COUNT_W-1:0] count_inc;
	logic               hit;
	logic               adv;

	assign rdy_s3 = !out_valid || out_ready;
	assign adv    = vld_s3 && rdy_s3;

	always_comb begin
		if (quot_s3 <= SUM_W'(LEVEL_OFFSET)) begin
			raw = '0;
		end else if (quot_s3 > SUM_W'(LEVEL_OFFSET + LEVEL_SAT)) begin
			raw = LAST_W'(LEVEL_SAT);
		end else begin
			raw = LAST_W'(quot_s3 - SUM_W'(LEVEL_OFFSET));
		end
		// level may only go down
		lvl   = (raw < last_q) ? raw : last_q;
		level = (lvl > LAST_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : lvl[LEVEL_W-1:0];
		count_inc = count_q + 1'b1;
		hit = (count_inc == cfg.interval) && cfg.notify_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			last_q    <= LAST_RST;
			count_q   <= '0;
		end else begin
			if (adv) begin
				out_valid <= 1'b1;
				last_q    <= lvl;
				count_q   <= hit ? '0 : count_inc;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_q    <= level;
			notify_q   <= hit;
			shutdown_q <= (level < cfg.threshold);
		end
	end

endmodule

// ===== bench/level_check_pkg.sv =====
`timescale 1ns / 1ps
// level_check_pkg: expected-level model and result checking for the battery level monitor bench
// depends on blm_pkg from src for widths, register indexes and level constants

package level_check_pkg;
	import blm_pkg::*;

	localparam int WIN_LEN = 5;

	// m_axis tdata fields from bit 0 up: level, notify, shutdown
	typedef struct packed {
		logic               shutdown;
		logic               notify;
		logic [LEVEL_W-1:0] level;
	} level_beat_t;

	class level_scoreboard;
		logic [SAMPLE_W-1:0] window [WIN_LEN];
		int unsigned         slot;
		logic [COUNT_W-1:0]  avg_count;
		logic [LAST_W-1:0]   floor_level;
		cfg_t                regs;
		level_beat_t         pending [$];
		int unsigned         mismatches;
		int unsigned         checked;
		int unsigned         notifies;
		int unsigned         shutdowns;
		int unsigned         refills;
		int unsigned         samples;

		function new();
			foreach (window[i]) window[i] = '0;
			slot = 0;
			avg_count = '0;
			floor_level = LAST_RST;
			regs.threshold = THRESHOLD_RST;
			regs.interval = INTERVAL_RST;
			regs.notify_en = 1'b0;
			mismatches = 0;
			checked = 0;
			notifies = 0;
			shutdowns = 0;
			refills = 0;
			samples = 0;
		endfunction

		function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_THRESHOLD: regs.threshold = data[THR_W-1:0];
				REG_INTERVAL:  regs.interval = data[INTV_W-1:0];
				REG_NOTIFY_EN: regs.notify_en = data[0];
				default: ;
			endcase
		endfunction

		function void take_sample(logic [SAMPLE_W-1:0] s);
			int unsigned sum;
			int unsigned q;
			int unsigned raw;
			int unsigned lvl;
			level_beat_t beat;
			samples++;
			// an empty entry 0 means the window is refilled, slot untouched
			if (window[0] == '0) begin
				foreach (window[i]) window[i] = s;
				refills++;
				return;
			end
			window[slot] = s;
			slot = (slot + 1) % WIN_LEN;
			if (slot != 0)
				return;
			avg_count = avg_count + 1'b1;
			sum = 0;
			foreach (window[i]) sum += window[i];
			// average volts = avg*3.6/1024*2, percent = (volts - 3.10)*100
			q = sum * 720 / (1024 * WIN_LEN);
			if (q <= LEVEL_OFFSET)
				raw = 0;
			else if (q - LEVEL_OFFSET > LEVEL_SAT)
				raw = LEVEL_SAT;
			else
				raw = q - LEVEL_OFFSET;
			lvl = (raw < floor_level) ? raw : floor_level;
			floor_level = LAST_W'(lvl);
			beat.level = (lvl > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(lvl);
			beat.notify = 1'b0;
			if (avg_count == regs.interval && regs.notify_en) begin
				beat.notify = 1'b1;
				avg_count = '0;
				notifies++;
			end
			beat.shutdown = (beat.level < regs.threshold);
			if (beat.shutdown)
				shutdowns++;
			pending.push_back(beat);
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		function void compare_level(logic [OUT_TDATA_W-1:0] tdata);
			level_beat_t got;
			level_beat_t want;
			got = tdata[$bits(level_beat_t)-1:0];
			checked++;
			if (pending.size() == 0) begin
				note_mismatch($sformatf("unexpected beat: level %0d notify %0b shutdown %0b",
					got.level, got.notify, got.shutdown));
				return;
			end
			want = pending.pop_front();
			if (got.level !== want.level || got.notify !== want.notify
					|| got.shutdown !== want.shutdown)
				note_mismatch($sformatf(
					"beat %0d: expected level %0d notify %0b shutdown %0b, got %0d %0b %0b",
					checked, want.level, want.notify, want.shutdown,
					got.level, got.notify, got.shutdown));
		endfunction

		function int unsigned outstanding();
			return pending.size();
		endfunction
	endclass

endpackage

// ===== bench/tb_battery_level_monitor.sv =====
`timescale 1ns / 1ps
// tb_battery_level_monitor: drives ADC samples and register writes into the battery level monitor
// depends on blm_pkg, level_check_pkg and the battery_level_monitor RTL

module tb_battery_level_monitor;
	import blm_pkg::*;
	import level_check_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 250;
	localparam int SEG_ITEMS     = 140;
	localparam int NOISY_ITEMS   = 40;
	localparam int MODE_B_FROM   = 450;
	localparam int QUIET_FROM    = 900;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int OPENING [24] = '{
		0, 0, 1023,
		1023, 1023, 1023, 1023, 1023,
		800, 800, 800, 800, 800,
		0, 760, 760, 760, 760, 760,
		1000, 1000, 1000, 1000, 1000
	};
	localparam int CLOSING [10] = '{100, 100, 100, 100, 100, 1023, 1023, 1023, 1023, 1023};
	localparam int THR_STEPS [8] = '{100, 0, 37, 64, 1, 99, 45, 80};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [9:0] adc_sample
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [6:0] level_percent, [7] notify, [8] shutdown
	logic                   cfg_we = 1'b0;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	level_scoreboard sb;
	int sent;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_request;

	battery_level_monitor #(.WINDOW_LEN(WIN_LEN)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d levels still due", CYCLE_LIMIT, sb.outstanding());
		$display("Simulation FAILED");
		$finish;
	end

	// result side: check every accepted beat, then pick the next ready
	initial begin : result_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.compare_level(m_axis_tdata);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	task automatic push_sample(input int value);
		if (sent < MODE_B_FROM) begin
			send_idle_pct = 38;
			recv_idle_pct = 68;
		end else if (sent < QUIET_FROM) begin
			send_idle_pct = 68;
			recv_idle_pct = 38;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		if ($urandom_range(99, 0) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'(value);
		do @(posedge clk); while (!s_axis_tready);
		sb.take_sample(SAMPLE_W'(value));
		sent++;
	endtask

	// slow discharge: base falls with the sample count, jitter stays small so the
	// running minimum walks down in small steps instead of dropping at once
	function automatic int next_sample(input bit calm);
		int base;
		int roll;
		int v;
		base = 1023 - sent * 480 / 1000;
		if (base < 420)
			base = 420;
		roll = $urandom_range(99, 0);
		if (calm && roll < 5)
			return $urandom_range(1023, base);
		if (!calm && roll < 3)
			return 0;
		if (!calm && roll < 18)
			return $urandom_range(1023, 0);
		v = base + int'($urandom_range(30, 0)) - 15;
		return (v > 1023) ? 1023 : v;
	endfunction

	task automatic run_random(input int count, input bit calm);
		repeat (count) push_sample(next_sample(calm));
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	initial begin : stimulus
		int seg;
		sb = new();
		sent = 0;
		hold_request = 0;
		send_idle_pct = 38;
		recv_idle_pct = 68;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// refills from an empty window, high saturation, clamp to 100, zero in entry 0
		foreach (OPENING[i]) push_sample(OPENING[i]);
		settle();

		// interval 0 with notify on only matches once the count wraps past 255
		write_reg(REG_INTERVAL, 8'd0);
		write_reg(REG_NOTIFY_EN, 8'd1);
		write_reg(REG_THRESHOLD, CFG_W'(THR_STEPS[0]));
		seg = 0;
		while (sb.notifies == 0 && seg < 12) begin
			if (seg > 0) begin
				settle();
				write_reg(REG_THRESHOLD, CFG_W'(THR_STEPS[seg % 8]));
			end
			if (seg == 1)
				hold_request = HOLD_CYCLES;
			run_random(SEG_ITEMS, 1'b1);
			seg++;
		end
		settle();

		write_reg(REG_THRESHOLD, 8'd50);
		write_reg(REG_INTERVAL, 8'd1);
		run_random(NOISY_ITEMS, 1'b0);
		settle();

		// bits above a register's width are dropped; index 3 selects nothing
		write_reg(REG_THRESHOLD, 8'hFF);
		write_reg(REG_INTERVAL, 8'd255);
		write_reg(REG_NOTIFY_EN, 8'hFE);
		write_reg(REG_UNUSED, 8'h5A);
		hold_request = HOLD_CYCLES;
		run_random(NOISY_ITEMS, 1'b0);
		settle();

		write_reg(REG_THRESHOLD, CFG_W'($urandom_range(100, 0)));
		write_reg(REG_INTERVAL, CFG_W'($urandom_range(9, 2)));
		write_reg(REG_NOTIFY_EN, 8'd1);
		run_random(NOISY_ITEMS, 1'b0);
		// low saturation, then a full-scale window that the minimum must hold down
		foreach (CLOSING[i]) push_sample(CLOSING[i]);
		settle();

		$display("covered %0d samples with %0d window refills, %0d levels checked",
			sb.samples, sb.refills, sb.checked);
		$display("including %0d notifications and %0d shutdown requests, %0d mismatches",
			sb.notifies, sb.shutdowns, sb.mismatches);
		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
